/* rtl/crc_cc_pkg.sv */
// ----------------------------------------------------------------------------
// crc_cc_pkg - shared types and constants of the CRC codeword checker
// Register codes, configuration and result records, reset values.
// ----------------------------------------------------------------------------
package crc_cc_pkg;

  localparam int MAX_GEN_BITS_DEF = 17;

  localparam int POLY_W     = 17;
  localparam int LEN_W      = 5;
  localparam int DW_W       = 4;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CNT_W      = 32;

  localparam logic [POLY_W-1:0] POLY_RST = POLY_W'(13);
  localparam logic [LEN_W-1:0]  LEN_RST  = LEN_W'(4);
  localparam logic [DW_W-1:0]   DW_RST   = DW_W'(4);

  // Output queue depth; a byte yields at most two results.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GEN_POLY = 2'd0,
    REG_GEN_LEN  = 2'd1,
    REG_DW_BITS  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [POLY_W-1:0] poly;
    logic [LEN_W-1:0]  gen_len;
    logic [DW_W-1:0]   dw_bits;
  } cfg_t;

  typedef struct packed {
    logic             last;
    logic [CNT_W-1:0] error_total;
    logic [CNT_W-1:0] codeword_total;
    logic [7:0]       decoded_byte;
    logic             byte_ready;
    logic             codeword_bad;
    logic [7:0]       dataword;
  } result_t;

endpackage

/* rtl/crc_cc_engine.sv */
// ----------------------------------------------------------------------------
// crc_cc_engine - per-byte codeword engine
// Holds the framing, remainder, packing and counter state and works one
// stream byte (eight remainder steps) per fire, yielding up to two results.
// ----------------------------------------------------------------------------
module crc_cc_engine #(
  parameter int MAX_GEN_BITS = crc_cc_pkg::MAX_GEN_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire_i,
  input  logic [7:0]                byte_i,
  input  logic                      start_i,
  input  crc_cc_pkg::cfg_t          cfg_i,
  output crc_cc_pkg::result_t [1:0] res_o,
  output logic [1:0]                n_res_o
);
  import crc_cc_pkg::*;

  localparam int REM_W = MAX_GEN_BITS - 1;
  localparam int GL_W  = $clog2(MAX_GEN_BITS + 1);
  localparam int IDX_W = $clog2(MAX_GEN_BITS + 8);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [7:0]       pad_r, pad_nxt;
  logic             hdr_r, hdr_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic [3:0]       bcnt_r, bcnt_nxt;
  logic [CNT_W-1:0] cwc_r, cwc_nxt;
  logic [CNT_W-1:0] errc_r, errc_nxt;

  logic [GL_W-1:0]         gl;
  logic                    dw4;
  logic [IDX_W-1:0]        cw_len;
  logic [REM_W-1:0]        rmask;
  logic [MAX_GEN_BITS-1:0] gmask;
  logic [MAX_GEN_BITS-1:0] gpoly;

  // Effective generator length and dataword size.
  always_comb begin
    if (int'(cfg_i.gen_len) < 2) begin
      gl = GL_W'(2);
    end else if (int'(cfg_i.gen_len) > MAX_GEN_BITS) begin
      gl = GL_W'(MAX_GEN_BITS);
    end else begin
      gl = GL_W'(cfg_i.gen_len);
    end
    dw4    = (cfg_i.dw_bits == DW_W'(4));
    cw_len = (dw4 ? IDX_W'(4) : IDX_W'(8)) + IDX_W'(gl) - IDX_W'(1);
    for (int i = 0; i < REM_W; i++) begin
      rmask[i] = (i < int'(gl) - 1);
    end
    for (int i = 0; i < MAX_GEN_BITS; i++) begin
      gmask[i] = (i < int'(gl));
    end
    gpoly = MAX_GEN_BITS'(cfg_i.poly) & gmask;
  end

  always_comb begin
    logic [MAX_GEN_BITS-1:0] t;
    logic                    b;
    logic [1:0]              n;
    logic [7:0]              dword;
    result_t                 r;
    rem_nxt  = rem_r;
    idx_nxt  = idx_r;
    data_nxt = data_r;
    pad_nxt  = pad_r;
    hdr_nxt  = hdr_r;
    acc_nxt  = acc_r;
    bcnt_nxt = bcnt_r;
    cwc_nxt  = cwc_r;
    errc_nxt = errc_r;
    res_o    = '0;
    n        = 2'd0;
    t        = '0;
    b        = 1'b0;
    dword    = '0;
    r        = '0;
    if (start_i) begin
      // Header beat: restart everything and load the padding count.
      rem_nxt  = '0;
      idx_nxt  = '0;
      data_nxt = '0;
      acc_nxt  = '0;
      bcnt_nxt = '0;
      cwc_nxt  = '0;
      errc_nxt = '0;
      pad_nxt  = byte_i;
      hdr_nxt  = 1'b1;
    end else if (hdr_r) begin
      for (int k = 7; k >= 0; k--) begin
        b = byte_i[k];
        if (pad_nxt != 8'd0) begin
          pad_nxt = pad_nxt - 8'd1;
        end else begin
          t = {MAX_GEN_BITS'(rem_nxt & rmask)} << 1;
          t[0] = b;
          if (t[gl - GL_W'(1)]) begin
            t = t ^ gpoly;
          end
          rem_nxt = t[REM_W-1:0] & rmask;
          if (idx_nxt < (dw4 ? IDX_W'(4) : IDX_W'(8))) begin
            data_nxt = {data_nxt[6:0], b};
          end
          idx_nxt = idx_nxt + IDX_W'(1);
          if (idx_nxt >= cw_len && n != 2'd2) begin
            dword = dw4 ? {4'd0, data_nxt[3:0]} : data_nxt;
            if (cwc_nxt != '1) begin
              cwc_nxt = cwc_nxt + CNT_W'(1);
            end
            if (rem_nxt != '0 && errc_nxt != '1) begin
              errc_nxt = errc_nxt + CNT_W'(1);
            end
            acc_nxt  = dw4 ? {acc_nxt[3:0], dword[3:0]} : dword;
            bcnt_nxt = bcnt_nxt + (dw4 ? 4'd4 : 4'd8);
            r = '0;
            r.dataword       = dword;
            r.codeword_bad   = (rem_nxt != '0);
            r.codeword_total = cwc_nxt;
            r.error_total    = errc_nxt;
            if (bcnt_nxt >= 4'd8) begin
              r.byte_ready   = 1'b1;
              r.decoded_byte = acc_nxt;
              bcnt_nxt       = 4'd0;
            end
            if (n == 2'd0) begin
              res_o[0] = r;
            end else begin
              res_o[1] = r;
            end
            n        = n + 2'd1;
            rem_nxt  = '0;
            idx_nxt  = '0;
            data_nxt = '0;
          end
        end
      end
      // Mark the final result of this byte.
      if (n == 2'd2) begin
        res_o[1].last = 1'b1;
      end else if (n == 2'd1) begin
        res_o[0].last = 1'b1;
      end
    end
    n_res_o = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      idx_r  <= '0;
      data_r <= '0;
      pad_r  <= '0;
      hdr_r  <= 1'b0;
      acc_r  <= '0;
      bcnt_r <= '0;
      cwc_r  <= '0;
      errc_r <= '0;
    end else if (fire_i) begin
      rem_r  <= rem_nxt;
      idx_r  <= idx_nxt;
      data_r <= data_nxt;
      pad_r  <= pad_nxt;
      hdr_r  <= hdr_nxt;
      acc_r  <= acc_nxt;
      bcnt_r <= bcnt_nxt;
      cwc_r  <= cwc_nxt;
      errc_r <= errc_nxt;
    end
  end

endmodule

/* rtl/crc_codeword_checker.sv */
// ----------------------------------------------------------------------------
// crc_codeword_checker - streaming CRC codeword checker
// Skips header padding, checks each codeword against the configured generator
// and emits one result beat per completed codeword.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock while the result queue has room,
// most significant bit first. A beat with in_tuser set is the header: its
// value is the number of padding bits to skip, and it clears the framing and
// both totals. Each accepted byte is registered, then worked combinationally
// by eight unrolled remainder steps and pushed into a four-deep result queue.
// A byte leaves the input register once the queue has room for two results,
// and the same edge puts its first result on the output, behind any results
// still queued. Sustained input rate is one byte per cycle while each byte
// completes at most one codeword and out_tready is high; a byte completing two
// codewords takes two output beats, and the single output port sets the pace.
// Bytes before the first header and bytes that complete no codeword produce
// no beat. Configuration (generator bits, generator length, dataword size)
// is written through the cfg_ port, which is always ready; write it only
// while no byte is in flight.
// ----------------------------------------------------------------------------
module crc_codeword_checker #(
  parameter int MAX_GEN_BITS = crc_cc_pkg::MAX_GEN_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,  // [7:0] data_byte
  input  logic                                in_tuser,  // [0] stream_start
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] dataword, [15:8] decoded_byte, [47:16] codeword_total,
  // [79:48] error_total
  output logic [79:0]                         out_tdata,
  output logic [1:0]                          out_tuser, // [0] codeword_bad, [1] byte_ready
  output logic                                out_tlast,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crc_cc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crc_cc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import crc_cc_pkg::*;

  // Configuration registers
  cfg_t cfg_r;

  // Input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;

  // Result queue
  result_t                q_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]  wr_ptr_r;
  logic [OUTQ_PTR_W-1:0]  rd_ptr_r;
  logic [OUTQ_CNT_W-1:0]  cnt_r, cnt_nxt;

  result_t [1:0] res;
  logic [1:0]    n_res;
  logic          fire;
  logic          pop;
  logic [1:0]    n_push;
  result_t       head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poly    <= POLY_RST;
      cfg_r.gen_len <= LEN_RST;
      cfg_r.dw_bits <= DW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GEN_POLY: cfg_r.poly    <= cfg_data[POLY_W-1:0];
        REG_GEN_LEN:  cfg_r.gen_len <= cfg_data[LEN_W-1:0];
        REG_DW_BITS:  cfg_r.dw_bits <= cfg_data[DW_W-1:0];
        default: ;
      endcase
    end
  end

  // Work the held byte only when the queue can take two results.
  assign pop  = out_tvalid && out_tready;
  assign fire = in_valid_r &&
                ((OUTQ_CNT_W + 1)'(cnt_r) + (OUTQ_CNT_W + 1)'(2) <=
                 (OUTQ_CNT_W + 1)'(OUTQ_DEPTH) + (OUTQ_CNT_W + 1)'(pop));
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  crc_cc_engine #(
    .MAX_GEN_BITS(MAX_GEN_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire_i  (fire),
    .byte_i  (in_byte_r),
    .start_i (in_start_r),
    .cfg_i   (cfg_r),
    .res_o   (res),
    .n_res_o (n_res)
  );

  assign n_push = fire ? n_res : 2'd0;

  // Push up to two results, pop one.
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= res[0];
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_r + OUTQ_PTR_W'(1)] <= res[1];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r + OUTQ_CNT_W'(n_push) - OUTQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OUTQ_PTR_W'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUTQ_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {head.error_total, head.codeword_total,
                       head.decoded_byte, head.dataword};
  assign out_tuser  = {head.byte_ready, head.codeword_bad};
  assign out_tlast  = head.last;

`ifndef NO_ASSERTIONS
  // Queue never overfills.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OUTQ_CNT_W'(OUTQ_DEPTH))
    else $error("result queue overfilled");

  // Occupancy follows pushes and pops.
  a_q_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt_r == $past(cnt_r) + OUTQ_CNT_W'($past(n_push))
                             - OUTQ_CNT_W'($past(pop)))
    else $error("result queue count mismatch");

  // Input stalls only while a byte is held and cannot be worked.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && !fire)
    else $error("input stalled without a held byte");

  // A header never produces results.
  a_hdr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_start_r |-> n_res == 2'd0)
    else $error("header beat produced a result");
`endif

endmodule
